[src/plhc_pkg.sv]
// types and constants shared by the pump level hysteresis controller
package plhc_pkg;

    localparam int LEVEL_W = 10;
    localparam int CNT_W   = 14;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    localparam logic [1:0] OP_SAMPLE = 2'd0;
    localparam logic [1:0] OP_TICK   = 2'd1;
    localparam logic [1:0] OP_MODE   = 2'd2;

    localparam logic [1:0] MODE_AUTO = 2'd0;
    localparam logic [1:0] MODE_ON   = 2'd1;
    localparam logic [1:0] MODE_STOP = 2'd2;

    localparam logic [2:0] CAUSE_NONE      = 3'd0;
    localparam logic [2:0] CAUSE_MANUAL    = 3'd1;
    localparam logic [2:0] CAUSE_AUTO      = 3'd2;
    localparam logic [2:0] CAUSE_DRY       = 3'd3;
    localparam logic [2:0] CAUSE_RUNTIME   = 3'd4;
    localparam logic [2:0] CAUSE_MODE_STOP = 3'd5;

    localparam logic [2:0] REG_ENABLE     = 3'd0;
    localparam logic [2:0] REG_ON_LEVEL   = 3'd1;
    localparam logic [2:0] REG_OFF_LEVEL  = 3'd2;
    localparam logic [2:0] REG_MAX_RUN    = 3'd3;
    localparam logic [2:0] REG_DRY_GUARD  = 3'd4;
    localparam logic [2:0] REG_ACTIVE_LOW = 3'd5;

    typedef struct packed {
        logic [1:0]         op;
        logic [LEVEL_W-1:0] level;
        logic [1:0]         new_mode;
    } item_t;

    typedef struct packed {
        logic             relay_drive;
        logic             running;
        logic [1:0]       cur_mode;
        logic             dry_blocked;
        logic [CNT_W-1:0] run_seconds;
        logic [2:0]       stop_cause;
    } result_t;

endpackage

[src/pump_level_hysteresis_controller.sv]
// pump level hysteresis controller top level
// an accepted item passes the input register and then the result register on its way to its result word
// throughput: one item per cycle; the result register takes a new word whenever it is
//   empty or its word is taken in the same cycle
// reset: asynchronous active low; pump stopped, mode auto, guard clear, run count zero,
//   registers at their defaults, both stages empty
module pump_level_hysteresis_controller
    import plhc_pkg::*;
#(
    parameter int unsigned MAX_RUN_LIMIT_MINUTES = 255
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [9:0]  cfg_data,
    input  logic        item_valid,
    output logic        item_stall,
    input  item_t       item,
    output logic        result_valid,
    input  logic        result_stall,
    output result_t     result
);

    localparam logic [7:0] LIMIT_CAP = 8'(MAX_RUN_LIMIT_MINUTES);

    logic               enable_reg;
    logic [LEVEL_W-1:0] on_level_reg;
    logic [LEVEL_W-1:0] off_level_reg;
    logic [7:0]         max_run_reg;
    logic [LEVEL_W-1:0] dry_level_reg;
    logic               active_low_reg;

    logic               running_reg, running_next;
    logic [1:0]         mode_reg, mode_next;
    logic               guard_reg, guard_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [2:0]         cause_next;

    logic               in_vld_reg;
    item_t              in_reg;
    logic               out_vld_reg;
    result_t            out_reg;
    result_t            out_next;

    logic               advance;
    logic [7:0]         lim_min;
    logic [CNT_W-1:0]   lim_ext;
    logic [CNT_W-1:0]   limit_sec;
    logic               blocked;

    assign advance      = in_vld_reg && (!out_vld_reg || !result_stall);
    assign item_stall   = in_vld_reg && !advance;
    assign result_valid = out_vld_reg;
    assign result       = out_reg;

    // runtime limit in seconds: minutes * 60 as 64 - 4
    assign lim_min   = (max_run_reg > LIMIT_CAP) ? LIMIT_CAP : max_run_reg;
    assign lim_ext   = {{(CNT_W-8){1'b0}}, lim_min};
    assign limit_sec = (lim_ext << 6) - (lim_ext << 2);
    assign blocked   = in_reg.level < dry_level_reg;

    always_comb
    begin
        running_next = running_reg;
        mode_next    = mode_reg;
        guard_next   = guard_reg;
        cnt_next     = cnt_reg;
        cause_next   = CAUSE_NONE;
        if (enable_reg)
        begin
            case (in_reg.op)
                OP_SAMPLE:
                begin
                    if (blocked && !guard_reg && running_next)
                    begin
                        running_next = 1'b0;
                        cnt_next     = '0;
                        cause_next   = CAUSE_DRY;
                    end
                    guard_next = blocked;
                    if (!blocked)
                    begin
                        if (running_next && cnt_next >= limit_sec)
                        begin
                            running_next = 1'b0;
                            cnt_next     = '0;
                            cause_next   = CAUSE_RUNTIME;
                            mode_next    = MODE_STOP;
                        end
                        if (running_next && mode_next == MODE_STOP)
                        begin
                            running_next = 1'b0;
                            cnt_next     = '0;
                            cause_next   = CAUSE_MANUAL;
                        end
                        if (!running_next && mode_next == MODE_ON)
                        begin
                            running_next = 1'b1;
                            cnt_next     = '0;
                        end
                        if (mode_next == MODE_AUTO)
                        begin
                            if (!running_next && in_reg.level < on_level_reg)
                            begin
                                running_next = 1'b1;
                                cnt_next     = '0;
                            end
                            if (running_next && in_reg.level >= off_level_reg)
                            begin
                                running_next = 1'b0;
                                cnt_next     = '0;
                                cause_next   = CAUSE_AUTO;
                            end
                        end
                    end
                end
                OP_TICK:
                begin
                    if (running_reg && cnt_reg != CNT_MAX)
                        cnt_next = cnt_reg + 1'b1;
                end
                OP_MODE:
                begin
                    if (in_reg.new_mode <= MODE_STOP && in_reg.new_mode != mode_reg)
                    begin
                        mode_next = in_reg.new_mode;
                        if (in_reg.new_mode == MODE_STOP && running_reg)
                        begin
                            running_next = 1'b0;
                            cnt_next     = '0;
                            cause_next   = CAUSE_MODE_STOP;
                        end
                    end
                end
                default:
                begin
                    running_next = running_reg;
                end
            endcase
        end

        out_next.relay_drive = running_next ^ active_low_reg;
        out_next.running     = running_next;
        out_next.cur_mode    = mode_next;
        out_next.dry_blocked = guard_next;
        out_next.run_seconds = running_next ? cnt_next : '0;
        out_next.stop_cause  = cause_next;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg     <= 1'b0;
            on_level_reg   <= LEVEL_W'(300);
            off_level_reg  <= LEVEL_W'(900);
            max_run_reg    <= 8'd30;
            dry_level_reg  <= LEVEL_W'(50);
            active_low_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ENABLE:     enable_reg     <= cfg_data[0];
                REG_ON_LEVEL:   on_level_reg   <= cfg_data[LEVEL_W-1:0];
                REG_OFF_LEVEL:  off_level_reg  <= cfg_data[LEVEL_W-1:0];
                REG_MAX_RUN:    max_run_reg    <= cfg_data[7:0];
                REG_DRY_GUARD:  dry_level_reg  <= cfg_data[LEVEL_W-1:0];
                REG_ACTIVE_LOW: active_low_reg <= cfg_data[0];
                default:        enable_reg     <= enable_reg;
            endcase
        end
    end

    // controller state and stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= 1'b0;
            mode_reg    <= MODE_AUTO;
            guard_reg   <= 1'b0;
            cnt_reg     <= '0;
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (!item_stall)
                in_vld_reg <= item_valid;
            if (advance)
            begin
                running_reg <= running_next;
                mode_reg    <= mode_next;
                guard_reg   <= guard_next;
                cnt_reg     <= cnt_next;
                out_vld_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // payload words
    always_ff @(posedge clk)
    begin
        if (!item_stall && item_valid)
            in_reg <= item;
        if (advance)
            out_reg <= out_next;
    end

endmodule

[tb/sv/tb_pump_level_hysteresis_controller.sv]
// testbench for the pump level hysteresis controller: queued stimulus, predictor, result check
`timescale 1ns / 100ps

module tb_pump_level_hysteresis_controller;
    import plhc_pkg::*;

    localparam int unsigned RUN_LIMIT_MIN = 255;
    localparam int unsigned CYCLE_LIMIT   = 400000;
    localparam int unsigned HOLD_CYCLES   = 300;
    localparam int unsigned PHASE_ITEMS   = 190;
    localparam int unsigned SAT_TICKS     = 24;

    localparam logic [1:0] OP_BAD   = 2'd3;
    localparam logic [1:0] MODE_BAD = 2'd3;

    localparam logic [2:0] REG_SPARE_A = 3'd6;
    localparam logic [2:0] REG_SPARE_B = 3'd7;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        cfg_we       = 1'b0;
    logic [2:0]  cfg_index    = '0;
    logic [9:0]  cfg_data     = '0;
    logic        item_valid   = 1'b0;
    logic        item_stall;
    item_t       item         = '0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    result_t     result;

    // register copy
    logic               en_cfg       = 1'b0;
    logic [LEVEL_W-1:0] on_cfg       = 10'd300;
    logic [LEVEL_W-1:0] off_cfg      = 10'd900;
    logic [7:0]         max_run_cfg  = 8'd30;
    logic [LEVEL_W-1:0] dry_cfg      = 10'd50;
    logic               inv_cfg      = 1'b0;

    // controller state copy
    logic               pump_q  = 1'b0;
    logic [1:0]         mode_q  = MODE_AUTO;
    logic               guard_q = 1'b0;
    logic [CNT_W-1:0]   secs_q  = '0;

    item_t       pending_items[$];
    result_t     expected_status[$];

    int          send_idle_pct  = 0;
    int          stall_idle_pct = 0;
    int          pressure_arm   = 0;
    int          pressure_seen  = 0;
    int unsigned hold_left      = 0;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;

    pump_level_hysteresis_controller u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always #1 clk = ~clk;

    task automatic predict_pump(input item_t it, output result_t r);
        logic [2:0]  why;
        logic        blocked;
        int unsigned lim;
        why = CAUSE_NONE;
        if (en_cfg)
        begin
            case (it.op)
                OP_SAMPLE:
                begin
                    blocked = (it.level < dry_cfg);
                    if (blocked && !guard_q && pump_q)
                    begin
                        pump_q = 1'b0;
                        secs_q = '0;
                        why    = CAUSE_DRY;
                    end
                    guard_q = blocked;
                    if (!blocked)
                    begin
                        if (pump_q)
                        begin
                            lim = (max_run_cfg > RUN_LIMIT_MIN) ? RUN_LIMIT_MIN : max_run_cfg;
                            if (secs_q >= lim * 60)
                            begin
                                pump_q = 1'b0;
                                secs_q = '0;
                                why    = CAUSE_RUNTIME;
                                mode_q = MODE_STOP;
                            end
                        end
                        if (pump_q && mode_q == MODE_STOP)
                        begin
                            pump_q = 1'b0;
                            secs_q = '0;
                            why    = CAUSE_MANUAL;
                        end
                        if (!pump_q && mode_q == MODE_ON)
                        begin
                            pump_q = 1'b1;
                            secs_q = '0;
                        end
                        if (mode_q == MODE_AUTO)
                        begin
                            if (!pump_q && it.level < on_cfg)
                            begin
                                pump_q = 1'b1;
                                secs_q = '0;
                            end
                            if (pump_q && it.level >= off_cfg)
                            begin
                                pump_q = 1'b0;
                                secs_q = '0;
                                why    = CAUSE_AUTO;
                            end
                        end
                    end
                end
                OP_TICK:
                begin
                    if (pump_q && secs_q != CNT_MAX)
                        secs_q = secs_q + 1'b1;
                end
                OP_MODE:
                begin
                    if (it.new_mode != MODE_BAD && it.new_mode != mode_q)
                    begin
                        mode_q = it.new_mode;
                        if (it.new_mode == MODE_STOP && pump_q)
                        begin
                            pump_q = 1'b0;
                            secs_q = '0;
                            why    = CAUSE_MODE_STOP;
                        end
                    end
                end
                default: ;
            endcase
        end
        r.relay_drive = pump_q ^ inv_cfg;
        r.running     = pump_q;
        r.cur_mode    = mode_q;
        r.dry_blocked = guard_q;
        r.run_seconds = pump_q ? secs_q : '0;
        r.stop_cause  = why;
    endtask

    // item driver
    always @(posedge clk)
    begin
        result_t exp_r;
        if (rst_n)
        begin
            if (item_valid && !item_stall)
            begin
                predict_pump(item, exp_r);
                expected_status.push_back(exp_r);
            end
            if (!item_valid || !item_stall)
            begin
                if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    item       <= pending_items.pop_front();
                    item_valid <= 1'b1;
                end
                else
                    item_valid <= 1'b0;
            end
        end
    end

    // result monitor and result stall driver
    always @(posedge clk)
    begin
        result_t exp_r;
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                if (expected_status.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result word %h", result);
                end
                else
                begin
                    exp_r = expected_status.pop_front();
                    if (result.relay_drive !== exp_r.relay_drive
                        || result.running !== exp_r.running
                        || result.cur_mode !== exp_r.cur_mode
                        || result.dry_blocked !== exp_r.dry_blocked
                        || result.run_seconds !== exp_r.run_seconds
                        || result.stop_cause !== exp_r.stop_cause)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display({"mismatch: relay %0d/%0d run %0d/%0d mode %0d/%0d ",
                                      "dry %0d/%0d secs %0d/%0d cause %0d/%0d (exp/act)"},
                                     exp_r.relay_drive, result.relay_drive,
                                     exp_r.running, result.running,
                                     exp_r.cur_mode, result.cur_mode,
                                     exp_r.dry_blocked, result.dry_blocked,
                                     exp_r.run_seconds, result.run_seconds,
                                     exp_r.stop_cause, result.stop_cause);
                    end
                end
            end
            if (pressure_arm != pressure_seen)
            begin
                pressure_seen = pressure_arm;
                hold_left     = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else
                result_stall <= ($urandom_range(99) < stall_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic push_item(input logic [1:0] op, input int lvl, input logic [1:0] nm);
        item_t it;
        it.op       = op;
        it.level    = LEVEL_W'(lvl);
        it.new_mode = nm;
        pending_items.push_back(it);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [9:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            REG_ENABLE:     en_cfg      = val[0];
            REG_ON_LEVEL:   on_cfg      = val;
            REG_OFF_LEVEL:  off_cfg     = val;
            REG_MAX_RUN:    max_run_cfg = val[7:0];
            REG_DRY_GUARD:  dry_cfg     = val;
            REG_ACTIVE_LOW: inv_cfg     = val[0];
            default: ;
        endcase
    endtask

    task automatic end_writes();
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic load_config(input logic [9:0] on_v, input logic [9:0] off_v,
                               input logic [7:0] maxr_v, input logic [9:0] dry_v,
                               input logic inv_v);
        write_reg(REG_ON_LEVEL, on_v);
        write_reg(REG_OFF_LEVEL, off_v);
        write_reg(REG_MAX_RUN, {2'b00, maxr_v});
        write_reg(REG_DRY_GUARD, dry_v);
        write_reg(REG_ACTIVE_LOW, {9'd0, inv_v});
        end_writes();
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_items.size() != 0 || item_valid || expected_status.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    initial
    begin
        int unsigned ph;
        int unsigned cnt;
        int          n;
        int          r;
        int          lvl;
        int          t;
        logic [9:0]  on_v;
        logic [9:0]  off_v;
        logic [9:0]  dry_v;
        logic [7:0]  maxr_v;
        logic        inv_v;
        logic [1:0]  nm_v;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // disabled after reset, then enable
        push_item(OP_SAMPLE, 100, MODE_AUTO);
        push_item(OP_MODE, 0, MODE_ON);
        wait_idle();
        write_reg(REG_ENABLE, 10'd1);
        write_reg(REG_SPARE_A, 10'h3ff);
        write_reg(REG_SPARE_B, 10'h155);
        end_writes();
        load_config(10'd300, 10'd900, 8'd30, 10'd50, 1'b0);

        push_item(OP_SAMPLE, 0, MODE_AUTO);
        push_item(OP_SAMPLE, 0, MODE_BAD);
        push_item(OP_SAMPLE, 1000, MODE_AUTO);
        push_item(OP_SAMPLE, 100, MODE_AUTO);
        push_item(OP_TICK, 1023, MODE_BAD);
        push_item(OP_TICK, 0, MODE_AUTO);
        push_item(OP_SAMPLE, 10, MODE_AUTO);
        push_item(OP_SAMPLE, 20, MODE_AUTO);
        push_item(OP_SAMPLE, 200, MODE_AUTO);
        push_item(OP_MODE, 0, MODE_ON);
        push_item(OP_MODE, 0, MODE_ON);
        push_item(OP_MODE, 0, MODE_BAD);
        push_item(OP_SAMPLE, 1000, MODE_AUTO);
        push_item(OP_BAD, 1023, MODE_BAD);
        push_item(OP_MODE, 0, MODE_STOP);
        push_item(OP_TICK, 0, MODE_AUTO);
        push_item(OP_SAMPLE, 500, MODE_AUTO);
        push_item(OP_MODE, 0, MODE_ON);
        push_item(OP_SAMPLE, 50, MODE_AUTO);
        push_item(OP_MODE, 0, MODE_AUTO);
        push_item(OP_SAMPLE, 950, MODE_AUTO);
        push_item(OP_SAMPLE, 299, MODE_AUTO);
        push_item(OP_SAMPLE, 49, MODE_AUTO);
        push_item(OP_SAMPLE, 512, MODE_AUTO);
        wait_idle();

        // items while disabled leave state alone
        write_reg(REG_ENABLE, 10'd0);
        end_writes();
        push_item(OP_SAMPLE, 100, MODE_AUTO);
        push_item(OP_MODE, 0, MODE_STOP);
        push_item(OP_TICK, 0, MODE_AUTO);
        push_item(OP_SAMPLE, 0, MODE_AUTO);
        wait_idle();
        write_reg(REG_ENABLE, 10'd1);
        end_writes();

        // start and stop in one sample, zero runtime limit
        load_config(10'd600, 10'd400, 8'd0, 10'd50, 1'b1);
        push_item(OP_MODE, 0, MODE_AUTO);
        push_item(OP_SAMPLE, 500, MODE_AUTO);
        push_item(OP_SAMPLE, 300, MODE_AUTO);
        push_item(OP_TICK, 0, MODE_AUTO);
        push_item(OP_SAMPLE, 300, MODE_AUTO);
        wait_idle();

        // run under the longest runtime limit
        load_config(10'd1000, 10'd1000, 8'd255, 10'd0, 1'b0);
        push_item(OP_MODE, 0, MODE_AUTO);
        push_item(OP_SAMPLE, 999, MODE_AUTO);
        repeat (SAT_TICKS) push_item(OP_TICK, 0, MODE_AUTO);
        push_item(OP_SAMPLE, 999, MODE_AUTO);
        wait_idle();

        for (ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0:
                begin
                    on_v = 10'd300; off_v = 10'd900; maxr_v = 8'd1; dry_v = 10'd50;
                    inv_v = 1'b0;
                end
                1:
                begin
                    on_v = 10'd1000; off_v = 10'd0; maxr_v = 8'd0; dry_v = 10'd0;
                    inv_v = 1'b1;
                end
                2:
                begin
                    on_v = 10'd0; off_v = 10'd1000; maxr_v = 8'd255; dry_v = 10'd1000;
                    inv_v = 1'b0;
                end
                3:
                begin
                    on_v = 10'd1000; off_v = 10'd1000; maxr_v = 8'd2; dry_v = 10'd0;
                    inv_v = 1'b1;
                end
                default:
                begin
                    on_v   = 10'($urandom_range(0, 1000));
                    off_v  = 10'($urandom_range(0, 1000));
                    maxr_v = ($urandom_range(3) == 0) ? 8'd255 : 8'($urandom_range(0, 2));
                    dry_v  = 10'($urandom_range(0, 300));
                    inv_v  = 1'($urandom_range(1));
                end
            endcase
            load_config(on_v, off_v, maxr_v, dry_v, inv_v);
            case (ph % 4)
                0:
                begin
                    send_idle_pct = 0;  stall_idle_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 61; stall_idle_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;  stall_idle_pct = 61;
                end
                default:
                begin
                    send_idle_pct = 35; stall_idle_pct = 35;
                end
            endcase

            cnt = 0;
            while (cnt < PHASE_ITEMS)
            begin
                case ($urandom_range(9))
                    0, 1, 2, 3: lvl = $urandom_range(0, 1000);
                    4: lvl = int'(on_v) + $urandom_range(0, 6) - 3;
                    5: lvl = int'(off_v) + $urandom_range(0, 6) - 3;
                    6: lvl = int'(dry_v) + $urandom_range(0, 6) - 3;
                    7:
                    begin
                        t = $urandom_range(4);
                        lvl = (t == 0) ? 0 : (t == 1) ? 1000 : (t == 2) ? 1023 :
                              (t == 3) ? 511 : 512;
                    end
                    default: lvl = $urandom_range(0, 1023);
                endcase
                if (lvl < 0)
                    lvl = 0;
                if (lvl > 1023)
                    lvl = 1023;
                nm_v = 2'($urandom_range(3));
                r = $urandom_range(99);
                if (r < 45)
                begin
                    push_item(OP_SAMPLE, lvl, nm_v);
                    cnt++;
                end
                else if (r < 75)
                begin
                    n = ($urandom_range(9) == 0) ? $urandom_range(20, 130) : 1;
                    repeat (n) push_item(OP_TICK, $urandom_range(0, 1023), 2'($urandom_range(3)));
                    cnt += n;
                end
                else if (r < 95)
                begin
                    t = $urandom_range(9);
                    nm_v = (t < 4) ? MODE_AUTO : (t < 7) ? MODE_ON : (t < 9) ? MODE_STOP : MODE_BAD;
                    push_item(OP_MODE, lvl, nm_v);
                    cnt++;
                end
                else
                begin
                    push_item(OP_BAD, lvl, nm_v);
                    cnt++;
                end
            end
            // long receiver hold-off while the sender keeps offering
            if (ph % 4 == 2)
                pressure_arm++;
            wait_idle();
        end

        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

[filelist.f]
src/plhc_pkg.sv
src/pump_level_hysteresis_controller.sv
tb/sv/tb_pump_level_hysteresis_controller.sv
